>>> rtl/irs_pkg.sv
// Shared constants and types for the interval record sorter.
`timescale 1ns / 1ps
package irs_pkg;

  localparam int unsigned TIME_W         = 64;
  localparam int unsigned ORDER_W        = 6;
  localparam int unsigned POOL_DEPTH_DEF = 64;
  localparam int unsigned LABEL_BITS_DEF = 16;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/irs_cell.sv
// One sorter cell: holds a record, compares it with the incoming one and passes data along.
`timescale 1ns / 1ps
module irs_cell #(
  parameter int unsigned LABEL_BITS = irs_pkg::LABEL_BITS_DEF,
  parameter int unsigned REC_W      = 2 * irs_pkg::TIME_W + LABEL_BITS + 1 + irs_pkg::ORDER_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irs_pkg::cell_ctrl_t ctrl_i,
  input  logic [REC_W-1:0]  new_rec_i,
  input  logic [REC_W-1:0]  prev_rec_i,
  input  logic              prev_valid_i,
  input  logic              prev_lt_i,
  input  logic [REC_W-1:0]  next_rec_i,
  input  logic              next_valid_i,
  output logic [REC_W-1:0]  rec_o,
  output logic              valid_o,
  output logic              lt_o
);
  import irs_pkg::*;

  localparam int unsigned KEY_W = 2 * TIME_W + LABEL_BITS;

  logic [REC_W-1:0] rec_q, rec_d;
  logic             valid_q, valid_d;
  logic [KEY_W-1:0] new_key, own_key;

  assign new_key = new_rec_i[REC_W-1 -: KEY_W];
  assign own_key = rec_q[REC_W-1 -: KEY_W];
  assign lt_o    = !valid_q || (new_key < own_key);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      rec_d   = next_rec_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert && lt_o) begin
      if (prev_lt_i) begin
        rec_d   = prev_rec_i;
        valid_d = prev_valid_i;
      end else begin
        rec_d   = new_rec_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o   = rec_q;
  assign valid_o = valid_q;

endmodule

>>> rtl/interval_record_sorter.sv
// Top level of the interval record sorter: cell chain, batch control and result register.
//
// Records load one per cycle (start high, busy low) into a chain of POOL_DEPTH cells
// that keeps them sorted by end time, start time and label on every insert. The item
// with batch_end closes the batch; from the next cycle busy stays high while the chain
// shifts its N stored records out of the head cell, one result per cycle, each on the
// result ports for one cycle with out_strobe_o. An empty batch gives a single result in
// the cycle after the closing item and never raises busy. The result port cannot be
// stalled; the drop_hidden register is written through the cfg channel, which is
// always ready.
`timescale 1ns / 1ps
module interval_record_sorter #(
  parameter int unsigned POOL_DEPTH = irs_pkg::POOL_DEPTH_DEF,
  parameter int unsigned LABEL_BITS = irs_pkg::LABEL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [LABEL_BITS-1:0]       label_i,
  input  logic [irs_pkg::TIME_W-1:0]  start_time_i,
  input  logic [irs_pkg::TIME_W-1:0]  end_time_i,
  input  logic                        hidden_flag_i,
  input  logic                        batch_end_i,
  output logic                        out_strobe_o,
  output logic [LABEL_BITS-1:0]       out_label_o,
  output logic [irs_pkg::TIME_W-1:0]  out_start_o,
  output logic [irs_pkg::TIME_W-1:0]  out_end_o,
  output logic                        out_hidden_o,
  output logic [irs_pkg::ORDER_W-1:0] arrival_order_o,
  output logic                        overflowed_o,
  output logic                        empty_batch_o,
  output logic                        last_out_o
);
  import irs_pkg::*;

  localparam int unsigned REC_W = 2 * TIME_W + LABEL_BITS + 1 + ORDER_W;
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic             drop_hidden_q;
  logic             overflow_q;
  logic             batch_ovf_q;

  logic [REC_W-1:0] rec_w   [POOL_DEPTH];
  logic             valid_w [POOL_DEPTH];
  logic             lt_w    [POOL_DEPTH];
  logic [REC_W-1:0] new_rec;
  cell_ctrl_t       ctrl;

  logic             accept, drop_h, full, ins;
  logic [CNT_W-1:0] count_nxt;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q == ST_DRAIN);
  assign accept      = start && !busy;
  assign drop_h      = hidden_flag_i && drop_hidden_q;
  assign full        = (count_q == CNT_W'(POOL_DEPTH));
  assign ins         = accept && !drop_h && !full;
  assign count_nxt   = count_q + CNT_W'(ins);

  assign new_rec     = {end_time_i, start_time_i, label_i, hidden_flag_i, ORDER_W'(count_q)};
  assign ctrl.insert = ins;
  assign ctrl.shift  = busy;

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    logic [REC_W-1:0] prev_rec, next_rec;
    logic             prev_valid, prev_lt, next_valid;

    if (i == 0) begin : g_head
      assign prev_rec   = new_rec;
      assign prev_valid = 1'b0;
      assign prev_lt    = 1'b0;
    end else begin : g_body
      assign prev_rec   = rec_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_lt    = lt_w[i-1];
    end

    if (i == POOL_DEPTH - 1) begin : g_tail
      assign next_rec   = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_rec   = rec_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    irs_cell #(
      .LABEL_BITS (LABEL_BITS),
      .REC_W      (REC_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .prev_rec_i   (prev_rec),
      .prev_valid_i (prev_valid),
      .prev_lt_i    (prev_lt),
      .next_rec_i   (next_rec),
      .next_valid_i (next_valid),
      .rec_o        (rec_w[i]),
      .valid_o      (valid_w[i]),
      .lt_o         (lt_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_hidden_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      drop_hidden_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_LOAD;
      count_q         <= '0;
      overflow_q      <= 1'b0;
      batch_ovf_q     <= 1'b0;
      out_strobe_o    <= 1'b0;
      out_label_o     <= '0;
      out_start_o     <= '0;
      out_end_o       <= '0;
      out_hidden_o    <= 1'b0;
      arrival_order_o <= '0;
      overflowed_o    <= 1'b0;
      empty_batch_o   <= 1'b0;
      last_out_o      <= 1'b0;
    end else begin
      out_strobe_o <= 1'b0;
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (batch_end_i) begin
              overflow_q  <= 1'b0;
              batch_ovf_q <= overflow_q || (!drop_h && full);
              if (count_nxt == '0) begin
                out_strobe_o    <= 1'b1;
                out_label_o     <= '0;
                out_start_o     <= '0;
                out_end_o       <= '0;
                out_hidden_o    <= 1'b0;
                arrival_order_o <= '0;
                overflowed_o    <= 1'b0;
                empty_batch_o   <= 1'b1;
                last_out_o      <= 1'b1;
              end else begin
                count_q <= count_nxt;
                state_q <= ST_DRAIN;
              end
            end else begin
              count_q <= count_nxt;
              if (!drop_h && full) begin
                overflow_q <= 1'b1;
              end
            end
          end
        end
        ST_DRAIN: begin
          out_strobe_o    <= 1'b1;
          out_end_o       <= rec_w[0][REC_W-1 -: TIME_W];
          out_start_o     <= rec_w[0][REC_W-TIME_W-1 -: TIME_W];
          out_label_o     <= rec_w[0][ORDER_W+1 +: LABEL_BITS];
          out_hidden_o    <= rec_w[0][ORDER_W];
          arrival_order_o <= rec_w[0][ORDER_W-1:0];
          overflowed_o    <= batch_ovf_q;
          empty_batch_o   <= 1'b0;
          last_out_o      <= (count_q == CNT_W'(1));
          count_q         <= count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

>>> rtl/irs_checker.sv
// Port-level checks for the interval record sorter, bound to the top level.
`timescale 1ns / 1ps
module irs_checker #(
  parameter int unsigned LABEL_BITS = irs_pkg::LABEL_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        busy,
  input logic                        out_strobe_o,
  input logic [LABEL_BITS-1:0]       out_label_o,
  input logic [irs_pkg::TIME_W-1:0]  out_start_o,
  input logic [irs_pkg::TIME_W-1:0]  out_end_o,
  input logic                        empty_batch_o,
  input logic                        last_out_o
);

  a_drain_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> out_strobe_o)
    else $error("drain cycle without a result");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && last_out_o) |-> !busy)
    else $error("busy after the last result of a batch");

  a_fall_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (out_strobe_o && last_out_o))
    else $error("drain ended without a last result");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && empty_batch_o) |->
      (last_out_o && out_label_o == '0 && out_start_o == '0 && out_end_o == '0))
    else $error("malformed empty-batch result");

endmodule

bind interval_record_sorter irs_checker #(.LABEL_BITS(LABEL_BITS)) u_irs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy          (busy),
  .out_strobe_o  (out_strobe_o),
  .out_label_o   (out_label_o),
  .out_start_o   (out_start_o),
  .out_end_o     (out_end_o),
  .empty_batch_o (empty_batch_o),
  .last_out_o    (last_out_o)
);

>>> verif/tb_top.sv
// Self-checking testbench for the interval record sorter: directed and random batches checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import irs_pkg::*;

  localparam int unsigned POOL  = POOL_DEPTH_DEF;
  localparam int unsigned LBITS = LABEL_BITS_DEF;
  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int PHASES        = 6;

  typedef logic [LBITS-1:0]  label_t;
  typedef logic [TIME_W-1:0] stamp_t;

  typedef struct packed {
    label_t label;
    stamp_t t_start;
    stamp_t t_end;
    logic   hidden;
  } interval_t;

  typedef struct packed {
    interval_t          rec;
    logic [ORDER_W-1:0] order;
    logic               overflowed;
    logic               empty;
    logic               last;
  } sorted_out_t;

  class interval_scoreboard;
    interval_t          pool[POOL];
    logic [ORDER_W-1:0] pool_order[POOL];
    int                 stored = 0;
    bit                 overflow_seen = 1'b0;
    bit                 drop_hidden = 1'b0;
    sorted_out_t        sorted_q[$];
    int                 errors = 0;
    int                 checked = 0;
    int                 batches = 0;
    int                 empty_batches = 0;
    int                 overflow_batches = 0;

    function bit sorts_first(interval_t a, interval_t b);
      return {a.t_end, a.t_start, a.label} < {b.t_end, b.t_start, b.label};
    endfunction

    function void note_input(interval_t r, bit closing);
      int          pos;
      sorted_out_t res;
      if (!(r.hidden && drop_hidden)) begin
        if (stored >= POOL) begin
          overflow_seen = 1'b1;
        end else begin
          pos = stored;
          while (pos > 0 && sorts_first(r, pool[pos-1])) begin
            pool[pos]       = pool[pos-1];
            pool_order[pos] = pool_order[pos-1];
            pos--;
          end
          pool[pos]       = r;
          pool_order[pos] = ORDER_W'(stored);
          stored++;
        end
      end
      if (!closing) return;
      batches++;
      if (stored == 0) begin
        res       = '0;
        res.empty = 1'b1;
        res.last  = 1'b1;
        sorted_q.push_back(res);
        empty_batches++;
      end else begin
        if (overflow_seen) overflow_batches++;
        for (int k = 0; k < stored; k++) begin
          res.rec        = pool[k];
          res.order      = pool_order[k];
          res.overflowed = overflow_seen;
          res.empty      = 1'b0;
          res.last       = (k == stored - 1);
          sorted_q.push_back(res);
        end
      end
      stored        = 0;
      overflow_seen = 1'b0;
    endfunction

    function int pending();
      return sorted_q.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s got %h exp %h", checked, name, got, want));
    endtask

    task check_result(sorted_out_t got);
      sorted_out_t want;
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item, label %h end %h", got.rec.label,
                                  got.rec.t_end));
        return;
      end
      want = sorted_q.pop_front();
      checked++;
      check_field("out_label", TIME_W'(got.rec.label), TIME_W'(want.rec.label));
      check_field("out_start", got.rec.t_start, want.rec.t_start);
      check_field("out_end", got.rec.t_end, want.rec.t_end);
      check_field("out_hidden", TIME_W'(got.rec.hidden), TIME_W'(want.rec.hidden));
      check_field("arrival_order", TIME_W'(got.order), TIME_W'(want.order));
      check_field("overflowed", TIME_W'(got.overflowed), TIME_W'(want.overflowed));
      check_field("empty_batch", TIME_W'(got.empty), TIME_W'(want.empty));
      check_field("last_out", TIME_W'(got.last), TIME_W'(want.last));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_data_i = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  label_t             label_i = '0;
  stamp_t             start_time_i = '0;
  stamp_t             end_time_i = '0;
  logic               hidden_flag_i = 1'b0;
  logic               batch_end_i = 1'b0;
  logic               out_strobe_o;
  label_t             out_label_o;
  stamp_t             out_start_o;
  stamp_t             out_end_o;
  logic               out_hidden_o;
  logic [ORDER_W-1:0] arrival_order_o;
  logic               overflowed_o;
  logic               empty_batch_o;
  logic               last_out_o;

  interval_scoreboard sb = new();
  sorted_out_t        seen;
  int                 cycles = 0;
  int                 items_sent = 0;

  interval_record_sorter #(
    .POOL_DEPTH(POOL),
    .LABEL_BITS(LBITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .label_i        (label_i),
    .start_time_i   (start_time_i),
    .end_time_i     (end_time_i),
    .hidden_flag_i  (hidden_flag_i),
    .batch_end_i    (batch_end_i),
    .out_strobe_o   (out_strobe_o),
    .out_label_o    (out_label_o),
    .out_start_o    (out_start_o),
    .out_end_o      (out_end_o),
    .out_hidden_o   (out_hidden_o),
    .arrival_order_o(arrival_order_o),
    .overflowed_o   (overflowed_o),
    .empty_batch_o  (empty_batch_o),
    .last_out_o     (last_out_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      seen.rec.label   = out_label_o;
      seen.rec.t_start = out_start_o;
      seen.rec.t_end   = out_end_o;
      seen.rec.hidden  = out_hidden_o;
      seen.order       = arrival_order_o;
      seen.overflowed  = overflowed_o;
      seen.empty       = empty_batch_o;
      seen.last        = last_out_o;
      sb.check_result(seen);
    end
  end

  function automatic interval_t make_interval(label_t l, stamp_t s, stamp_t e, logic h);
    interval_t r;
    r.label   = l;
    r.t_start = s;
    r.t_end   = e;
    r.hidden  = h;
    return r;
  endfunction

  // bias toward extremes and tiny values so that key ties are common
  function automatic stamp_t pick_stamp();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return stamp_t'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic label_t pick_label();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return label_t'($urandom_range(0, 2));
      default: return label_t'($urandom);
    endcase
  endfunction

  function automatic int pick_batch_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom_range(1, 6);
    if (sel < 85) return $urandom_range(7, 24);
    if (sel < 95) return $urandom_range(60, 68);
    return $urandom_range(69, 90);
  endfunction

  function automatic int pick_hide_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 30;
      2:       return 70;
      default: return 100;
    endcase
  endfunction

  task automatic send_record(interval_t r, bit closing, int gap);
    @(negedge clk_i);
    label_i       = r.label;
    start_time_i  = r.t_start;
    end_time_i    = r.t_end;
    hidden_flag_i = r.hidden;
    batch_end_i   = closing;
    start         = 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_input(r, closing);
    items_sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_drop_hidden(bit value);
    wait_for_drain();
    @(negedge clk_i);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.drop_hidden = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_batch(int batch_size, int hide_pct, bit burst);
    interval_t r;
    for (int i = 0; i < batch_size; i++) begin
      r = make_interval(pick_label(), pick_stamp(), pick_stamp(),
                        $urandom_range(0, 99) < hide_pct);
      send_record(r, i == batch_size - 1, burst ? 0 : $urandom_range(0, 4));
    end
  endtask

  initial begin
    int batch_size;
    int budget;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_record(make_interval('1, '1, '1, 1'b1), 1'b1, 0);

    send_record(make_interval(16'd3, 64'd7, 64'd5, 1'b0), 1'b0, 0);
    send_record(make_interval(16'd3, 64'd7, 64'd5, 1'b0), 1'b0, 1);
    send_record(make_interval(16'd2, 64'd7, 64'd5, 1'b0), 1'b0, 0);
    send_record(make_interval('1, 64'd0, 64'd5, 1'b0), 1'b0, 2);
    send_record(make_interval('1, '1, 64'd0, 1'b1), 1'b0, 0);
    send_record(make_interval('0, '0, '1, 1'b0), 1'b0, 3);
    send_record(make_interval('0, '0, '0, 1'b0), 1'b0, 0);
    send_record(make_interval('0, '1, 64'd4, 1'b1), 1'b1, 4);

    write_drop_hidden(1'b1);
    send_record(make_interval(16'd9, 64'd1, 64'd1, 1'b1), 1'b0, 0);
    send_record(make_interval(16'd8, 64'd2, 64'd2, 1'b0), 1'b0, 0);
    send_record(make_interval(16'd7, 64'd3, 64'd3, 1'b1), 1'b1, 1);
    send_record(make_interval('1, '1, '1, 1'b1), 1'b1, 0);
    send_record(make_interval(16'd1, '0, '1, 1'b1), 1'b0, 2);
    send_record(make_interval(16'd2, '1, '0, 1'b1), 1'b0, 0);
    send_record(make_interval(16'd3, 64'd5, 64'd6, 1'b1), 1'b1, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      write_drop_hidden(phase[0]);
      budget = items_sent + RANDOM_ITEMS / PHASES;
      // open the first two phases with a batch larger than the pool under each setting
      if (phase == 0) run_batch(65, 20, 1'b0);
      if (phase == 1) run_batch(70, 5, 1'b1);
      while (items_sent < budget) begin
        batch_size = pick_batch_size();
        if (batch_size > budget - items_sent) batch_size = budget - items_sent;
        run_batch(batch_size, pick_hide_pct(), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) wait_for_drain();
      end
    end

    wait_for_drain();
    $display("Sent %0d items in %0d batches: %0d empty, %0d overflowing, drop_hidden 0 and 1.",
             items_sent, sb.batches, sb.empty_batches, sb.overflow_batches);
    $display("Checked %0d sorted results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> interval_record_sorter.f
rtl/irs_pkg.sv
rtl/irs_cell.sv
rtl/interval_record_sorter.sv
rtl/irs_checker.sv
verif/tb_top.sv
